FILE: hdl/csvf_pkg.sv
// Shared types, widths and constants of the cascaded state-variable filter.
`default_nettype none

package csvf_pkg;

  // Integrator width and fixed-point layout
  localparam int STATE_W     = 40;
  localparam int FRAC_BITS   = 27;
  localparam int SAMPLE_W    = 24;
  localparam int COEF_W      = 17;
  localparam int KEY_W       = 7;
  localparam int COEF_SHIFT  = 16;
  localparam int AUDIO_SHIFT = FRAC_BITS - 19 + 4;
  localparam int OUT_SHIFT   = FRAC_BITS + 32 - 19;
  localparam int KEY_SHIFT   = 9;

  // Shared multiplier operands and product
  localparam int OPA_W  = 29;
  localparam int OPB_W  = STATE_W;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int SUM_W  = STATE_W + 14;

  // Coefficient widths
  localparam int BASE_W = COEF_W + 1;
  localparam int FRAW_W = 22;
  localparam int DAMP_W = 20;
  localparam int GAIN_W = 28;

  // Floored divide of the modulation product by 12 * 2^19:
  // shift by 21, bias positive, multiply by a reciprocal of 3, unbias
  localparam int MOD_SHIFT   = 21;
  localparam int MOD_T_W     = 20;
  localparam int U_W         = 21;
  localparam int RECIP_SHIFT = 21;
  localparam int FQ_W        = 20;
  localparam logic [20:0] RECIP3      = 21'd699051;
  localparam logic [20:0] DIV_BIAS_3K = 21'd524289;
  localparam logic [20:0] DIV_BIAS_K  = 21'd174763;

  // Damping and gain constants
  localparam logic [16:0] DAMP_K  = 17'd129106;
  localparam logic [16:0] GAIN_K  = 17'd1647;
  localparam logic [17:0] TWO_Q16 = 18'd131072;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_CUTOFF    = 3'd0,
    REG_RESONANCE = 3'd1,
    REG_MOD_DEPTH = 3'd2,
    REG_KEY_TRACK = 3'd3,
    REG_OUT_GAIN  = 3'd4,
    REG_RESP_SEL  = 3'd5,
    REG_CUT_LIMIT = 3'd6
  } cfg_reg_t;

  // Response select codes
  localparam logic [1:0] RESP_BAND = 2'd1;
  localparam logic [1:0] RESP_HIGH = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] audio_in;
    logic signed [SAMPLE_W-1:0] mod_in;
    logic [KEY_W-1:0]           note_key;
    logic                       note_start;
    logic signed [SAMPLE_W-1:0] mix_in;
  } csvf_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mix_out;
  } csvf_out_t;

  typedef struct packed {
    logic signed [OPA_W-1:0] a;
    logic signed [OPB_W-1:0] b;
  } mul_req_t;

  // Clamp a wide sum to the signed integrator range
  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = {{(SUM_W - STATE_W + 1){1'b0}}, {(STATE_W - 1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[STATE_W-1:0];
    end else if (v < lo) begin
      return lo[STATE_W-1:0];
    end
    return v[STATE_W-1:0];
  endfunction

  // Clamp a sum to the signed sample range
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [STATE_W-1:0] v);
    logic signed [STATE_W-1:0] hi;
    logic signed [STATE_W-1:0] lo;
    hi = {{(STATE_W - SAMPLE_W + 1){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[SAMPLE_W-1:0];
    end else if (v < lo) begin
      return lo[SAMPLE_W-1:0];
    end
    return v[SAMPLE_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/csvf_if.sv
// Valid/ready channel interfaces for filter samples and results.
`default_nettype none

interface csvf_in_if import csvf_pkg::*; ();
  logic     valid;
  logic     ready;
  csvf_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface csvf_out_if import csvf_pkg::*; ();
  logic      valid;
  logic      ready;
  csvf_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/csvf_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none

module csvf_mul import csvf_pkg::*; (
  input  wire logic                     clk,
  input  wire mul_req_t                 req,
  output logic signed [PROD_W-1:0]      prod_r
);

  logic signed [PROD_W-1:0] prod_nxt;

  // Multiply the selected operand pair
  assign prod_nxt = PROD_W'($signed(req.a)) * PROD_W'($signed(req.b));

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

`default_nettype wire

FILE: hdl/cascaded_state_variable_filter_unit.sv
// Two cascaded state-variable filter sections sharing one multiplier.
//
// One sample is accepted, then processed by a sequencer that feeds a single
// registered 29 x 40 multiplier: key tracking, modulation, a floored divide
// by 12, damping and gain coefficients, then the six integrator products of
// the two sections and the output gain. The block takes no new sample until
// the last one has left the sequencer, as the chain of dependent multiplies
// runs through the one shared multiplier. The finished result sits in an
// output register, so the next sample is taken while it waits; if a result
// still waits when the next one finishes, the last step holds. Integrators
// saturate to 40 bits; note_start zeroes them before the sample.
`default_nettype none

module cascaded_state_variable_filter_unit import csvf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  csvf_in_if.sink          in_ch,
  csvf_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [16:0] cfg_data
);

  typedef enum logic [16:0] {
    ST_IDLE  = 17'b00000000000000001,
    ST_KEY   = 17'b00000000000000010,
    ST_MOD   = 17'b00000000000000100,
    ST_DIV   = 17'b00000000000001000,
    ST_FCO   = 17'b00000000000010000,
    ST_DAMP  = 17'b00000000000100000,
    ST_GAIN  = 17'b00000000001000000,
    ST_LOW1  = 17'b00000000010000000,
    ST_HP1   = 17'b00000000100000000,
    ST_LOW2  = 17'b00000001000000000,
    ST_BAND1 = 17'b00000010000000000,
    ST_HP2   = 17'b00000100000000000,
    ST_MULHP = 17'b00001000000000000,
    ST_BAND2 = 17'b00010000000000000,
    ST_SEL   = 17'b00100000000000000,
    ST_MIX   = 17'b01000000000000000,
    ST_SPARE = 17'b10000000000000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [COEF_W-1:0] cutoff_r, cutoff_nxt;
  logic [COEF_W-1:0] resonance_r, resonance_nxt;
  logic [COEF_W-1:0] mod_depth_r, mod_depth_nxt;
  logic [COEF_W-1:0] key_track_r, key_track_nxt;
  logic [COEF_W-1:0] out_gain_r, out_gain_nxt;
  logic [1:0]        resp_sel_r, resp_sel_nxt;
  logic [COEF_W-1:0] cut_limit_r, cut_limit_nxt;

  // Sample operands
  logic signed [SAMPLE_W-1:0] audio_r, audio_nxt;
  logic signed [SAMPLE_W-1:0] mod_r, mod_nxt;
  logic [KEY_W-1:0]           key_r, key_nxt;
  logic signed [SAMPLE_W-1:0] mix_r, mix_nxt;

  // Per-sample coefficients
  logic [BASE_W-1:0]        base_r, base_nxt;
  logic [COEF_W-1:0]        f_r, f_nxt;
  logic signed [DAMP_W-1:0] q_r, q_nxt;
  logic [GAIN_W-1:0]        g_r, g_nxt;

  // Integrators and highpass node
  logic signed [STATE_W-1:0] band1_r, band1_nxt;
  logic signed [STATE_W-1:0] low1_r, low1_nxt;
  logic signed [STATE_W-1:0] band2_r, band2_nxt;
  logic signed [STATE_W-1:0] low2_r, low2_nxt;
  logic signed [STATE_W-1:0] hp_r, hp_nxt;

  // Output register
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_data_r, out_data_nxt;

  // Shared multiplier
  mul_req_t                 mul_req;
  logic signed [PROD_W-1:0] prod_r;

  // Datapath taps
  logic                        in_xfer;
  logic                        out_xfer;
  logic                        can_write;
  logic signed [SUM_W-1:0]     prod_q16;
  logic signed [SUM_W-1:0]     x_ext;
  logic signed [STATE_W-1:0]   y_ext;
  logic signed [MOD_T_W-1:0]   mod_t;
  logic signed [FRAW_W-1:0]    u_sum;
  logic signed [FRAW_W-1:0]    f_mod;
  logic signed [FRAW_W-1:0]    f_raw;
  logic signed [STATE_W-1:0]   sel_val;

  csvf_mul u_mul (
    .clk    (clk),
    .req    (mul_req),
    .prod_r (prod_r)
  );

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data.mix_out = out_data_r;
  assign out_xfer     = out_valid_r && out_ch.ready;
  assign can_write    = !out_valid_r || out_ch.ready;

  // Product scaled by a Q1.16 or signed Q2.16 coefficient, floored
  assign prod_q16 = SUM_W'($signed(prod_r[PROD_W-1:COEF_SHIFT]));
  assign x_ext    = SUM_W'(audio_r) <<< AUDIO_SHIFT;
  assign y_ext    = STATE_W'($signed(prod_r[PROD_W-1:OUT_SHIFT]));

  // Floored divide of the modulation term: bias, then reciprocal
  assign mod_t = $signed(prod_r[MOD_SHIFT+MOD_T_W-1:MOD_SHIFT]);
  assign u_sum = FRAW_W'(mod_t) + FRAW_W'($signed({1'b0, DIV_BIAS_3K}));
  assign f_mod = $signed({2'b00, prod_r[RECIP_SHIFT+FQ_W-1:RECIP_SHIFT]})
               - FRAW_W'($signed({1'b0, DIV_BIAS_K}));
  assign f_raw = $signed({3'b000, base_r, 1'b0}) + f_mod;

  // Pick the response of the second section
  always_comb begin
    case (resp_sel_r)
      RESP_BAND: sel_val = band2_r;
      RESP_HIGH: sel_val = hp_r;
      default:   sel_val = low2_r;
    endcase
  end

  // Route operands to the shared multiplier
  always_comb begin
    mul_req.a = OPA_W'($signed({1'b0, g_r}));
    mul_req.b = sel_val;
    unique case (state_r) inside
      ST_KEY: begin
        mul_req.a = OPA_W'($signed({1'b0, key_track_r}));
        mul_req.b = OPB_W'($signed({1'b0, key_r}));
      end
      ST_MOD: begin
        mul_req.a = OPA_W'($signed({1'b0, mod_depth_r}));
        mul_req.b = OPB_W'(mod_r);
      end
      ST_DIV: begin
        mul_req.a = OPA_W'($signed({1'b0, RECIP3}));
        mul_req.b = OPB_W'($signed({1'b0, u_sum[U_W-1:0]}));
      end
      ST_FCO: begin
        mul_req.a = OPA_W'($signed({1'b0, resonance_r}));
        mul_req.b = OPB_W'($signed({1'b0, DAMP_K}));
      end
      ST_DAMP: begin
        mul_req.a = OPA_W'($signed({1'b0, out_gain_r}));
        mul_req.b = OPB_W'($signed({1'b0, GAIN_K}));
      end
      ST_GAIN: begin
        mul_req.a = OPA_W'($signed({1'b0, f_r}));
        mul_req.b = band1_r;
      end
      ST_LOW1: begin
        mul_req.a = OPA_W'(q_r);
        mul_req.b = band1_r;
      end
      ST_HP1: begin
        mul_req.a = OPA_W'($signed({1'b0, f_r}));
        mul_req.b = band2_r;
      end
      ST_LOW2, ST_MULHP: begin
        mul_req.a = OPA_W'($signed({1'b0, f_r}));
        mul_req.b = hp_r;
      end
      ST_BAND1: begin
        mul_req.a = OPA_W'(q_r);
        mul_req.b = band2_r;
      end
      default: begin
        mul_req.a = OPA_W'($signed({1'b0, g_r}));
        mul_req.b = sel_val;
      end
    endcase
  end

  // Sequence one sample through the shared multiplier
  always_comb begin
    state_nxt     = state_r;
    cutoff_nxt    = cutoff_r;
    resonance_nxt = resonance_r;
    mod_depth_nxt = mod_depth_r;
    key_track_nxt = key_track_r;
    out_gain_nxt  = out_gain_r;
    resp_sel_nxt  = resp_sel_r;
    cut_limit_nxt = cut_limit_r;
    audio_nxt     = audio_r;
    mod_nxt       = mod_r;
    key_nxt       = key_r;
    mix_nxt       = mix_r;
    base_nxt      = base_r;
    f_nxt         = f_r;
    q_nxt         = q_r;
    g_nxt         = g_r;
    band1_nxt     = band1_r;
    low1_nxt      = low1_r;
    band2_nxt     = band2_r;
    low2_nxt      = low2_r;
    hp_nxt        = hp_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // Drop the result once it is transferred
    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          audio_nxt = in_ch.data.audio_in;
          mod_nxt   = in_ch.data.mod_in;
          key_nxt   = in_ch.data.note_key;
          mix_nxt   = in_ch.data.mix_in;
          if (in_ch.data.note_start) begin
            band1_nxt = '0;
            low1_nxt  = '0;
            band2_nxt = '0;
            low2_nxt  = '0;
          end
          state_nxt = ST_KEY;
        end
      end
      ST_KEY: begin
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        base_nxt  = {1'b0, cutoff_r} + BASE_W'(prod_r[KEY_SHIFT+14:KEY_SHIFT]);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        state_nxt = ST_FCO;
      end
      ST_FCO: begin
        // Clamp to the limit first, then to one LSB
        if (f_raw > $signed({5'b00000, cut_limit_r})) begin
          f_nxt = cut_limit_r;
        end else begin
          f_nxt = f_raw[COEF_W-1:0];
        end
        if (f_raw < FRAW_W'(1) && cut_limit_r != '0) begin
          f_nxt = COEF_W'(1);
        end else if (cut_limit_r == '0) begin
          f_nxt = COEF_W'(1);
        end
        state_nxt = ST_DAMP;
      end
      ST_DAMP: begin
        q_nxt     = $signed({2'b00, TWO_Q16})
                  - $signed({1'b0, prod_r[COEF_SHIFT+18:COEF_SHIFT]});
        state_nxt = ST_GAIN;
      end
      ST_GAIN: begin
        g_nxt     = prod_r[GAIN_W-1:0];
        state_nxt = ST_LOW1;
      end
      ST_LOW1: begin
        low1_nxt  = sat_state(SUM_W'(low1_r) + prod_q16);
        state_nxt = ST_HP1;
      end
      ST_HP1: begin
        hp_nxt    = sat_state(x_ext - SUM_W'(low1_r) - prod_q16);
        state_nxt = ST_LOW2;
      end
      ST_LOW2: begin
        low2_nxt  = sat_state(SUM_W'(low2_r) + prod_q16);
        state_nxt = ST_BAND1;
      end
      ST_BAND1: begin
        band1_nxt = sat_state(SUM_W'(band1_r) + prod_q16);
        state_nxt = ST_HP2;
      end
      ST_HP2: begin
        hp_nxt    = sat_state(SUM_W'(low1_r) - SUM_W'(low2_r) - prod_q16);
        state_nxt = ST_MULHP;
      end
      ST_MULHP: begin
        state_nxt = ST_BAND2;
      end
      ST_BAND2: begin
        band2_nxt = sat_state(SUM_W'(band2_r) + prod_q16);
        state_nxt = ST_SEL;
      end
      ST_SEL: begin
        state_nxt = ST_MIX;
      end
      ST_MIX: begin
        // Hold until the output register is free
        if (can_write) begin
          out_data_nxt  = sat_sample(STATE_W'(mix_r) + y_ext);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Register writes
    if (cfg_we) begin
      unique case (cfg_index)
        REG_CUTOFF:    cutoff_nxt    = cfg_data;
        REG_RESONANCE: resonance_nxt = cfg_data;
        REG_MOD_DEPTH: mod_depth_nxt = cfg_data;
        REG_KEY_TRACK: key_track_nxt = cfg_data;
        REG_OUT_GAIN:  out_gain_nxt  = cfg_data;
        REG_RESP_SEL:  resp_sel_nxt  = cfg_data[1:0];
        REG_CUT_LIMIT: cut_limit_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Control state, configuration and integrators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cutoff_r    <= COEF_W'(32768);
      resonance_r <= COEF_W'(32768);
      mod_depth_r <= COEF_W'(65536);
      key_track_r <= '0;
      out_gain_r  <= COEF_W'(65536);
      resp_sel_r  <= '0;
      cut_limit_r <= COEF_W'(65536);
      band1_r     <= '0;
      low1_r      <= '0;
      band2_r     <= '0;
      low2_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cutoff_r    <= cutoff_nxt;
      resonance_r <= resonance_nxt;
      mod_depth_r <= mod_depth_nxt;
      key_track_r <= key_track_nxt;
      out_gain_r  <= out_gain_nxt;
      resp_sel_r  <= resp_sel_nxt;
      cut_limit_r <= cut_limit_nxt;
      band1_r     <= band1_nxt;
      low1_r      <= low1_nxt;
      band2_r     <= band2_nxt;
      low2_r      <= low2_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    audio_r    <= audio_nxt;
    mod_r      <= mod_nxt;
    key_r      <= key_nxt;
    mix_r      <= mix_nxt;
    base_r     <= base_nxt;
    f_r        <= f_nxt;
    q_r        <= q_nxt;
    g_r        <= g_nxt;
    hp_r       <= hp_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while a sample is in flight");

  a_coef_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DAMP) |-> ((f_r != '0) && ((f_r <= cut_limit_r) || (f_r == COEF_W'(1)))))
    else $error("frequency coefficient outside its clamp");

  a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_MIX) && can_write) |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("finished sample did not reach the output register");
`endif

endmodule

`default_nettype wire

FILE: sim/tb_cascaded_state_variable_filter_unit.sv
// Testbench for the cascaded state-variable filter: directed and random samples vs a predictor.
`timescale 1ns / 100ps

module tb_cascaded_state_variable_filter_unit import csvf_pkg::*; ();

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 24;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 112;
  localparam int PCT_IDLE     = 31;
  localparam int CALM_PHASE   = 5;

  // Fixed-point constants of the filter
  localparam int     INTEG_W     = STATE_W;
  localparam int     SECT_SHIFT  = COEF_SHIFT;
  localparam int     GAIN_SHIFT  = OUT_SHIFT;
  localparam int     DRIVE_SHIFT = AUDIO_SHIFT;
  localparam longint DAMPING_K   = 129106;
  localparam longint GAIN_SCALE  = 1647;
  localparam longint DAMP_TWO    = 131072;
  localparam longint MOD_DIVISOR = 12 * (64'd1 << 19);

  localparam logic [16:0] COEF_TOP  = 17'd131071;
  localparam logic [16:0] COEF_ONE  = 17'd65536;
  localparam logic [16:0] COEF_HALF = 17'd32768;
  localparam logic [16:0] COEF_ZERO = 17'd0;

  localparam logic [1:0] RESP_LOW     = 2'd0;
  localparam logic [1:0] RESP_LOW_ALT = 2'd3;

  localparam logic signed [23:0] SAMPLE_MAX  = 24'sh7FFFFF;
  localparam logic signed [23:0] SAMPLE_MIN  = 24'sh800000;
  localparam logic signed [23:0] SAMPLE_ZERO = 24'sh000000;
  localparam logic [6:0]         KEY_TOP     = 7'd127;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [16:0] cfg_data;

  csvf_in_if  in_ch ();
  csvf_out_if out_ch ();

  cascaded_state_variable_filter_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow registers and integrators of the predictor
  longint     reg_cutoff    = 32768;
  longint     reg_resonance = 32768;
  longint     reg_mod_depth = 65536;
  longint     reg_key_track = 0;
  longint     reg_out_gain  = 65536;
  logic [1:0] reg_response  = RESP_LOW;
  longint     reg_cut_limit = 65536;
  longint     band_a = 0;
  longint     low_a  = 0;
  longint     band_b = 0;
  longint     low_b  = 0;

  csvf_in_t                   pending_samples[$];
  logic signed [SAMPLE_W-1:0] expected_mix[$];
  int                         idle_pct = PCT_IDLE;
  int                         errors   = 0;
  int                         stall_cycles;

  // floor(a*b / 2^sh), magnitude limited to 2^62
  function automatic longint mul_floor(input longint a, input longint b, input int sh);
    logic signed [127:0] wa, wb, p, lim;
    wa  = a;
    wb  = b;
    p   = (wa * wb) >>> sh;
    lim = 128'sd1 <<< 62;
    if (p > lim) begin
      p = lim;
    end else if (p < -lim) begin
      p = -lim;
    end
    return longint'(p[63:0]);
  endfunction

  function automatic longint clamp_integ(input longint v);
    longint hi, lo;
    hi = (64'sd1 <<< (INTEG_W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Run one sample through both sections and return the mixed output
  function automatic logic signed [SAMPLE_W-1:0] filter_sample(input csvf_in_t s);
    longint audio, modv, mixv, prod, mod_term, f, q, g, drive, hp_a, hp_b, tap, r;
    audio = s.audio_in;
    modv  = s.mod_in;
    mixv  = s.mix_in;
    if (s.note_start) begin
      band_a = 0;
      low_a  = 0;
      band_b = 0;
      low_b  = 0;
    end

    // Per-sample frequency coefficient, upper clamp first
    prod = reg_mod_depth * modv;
    if (prod >= 0) begin
      mod_term = prod / MOD_DIVISOR;
    end else begin
      mod_term = -((-prod + MOD_DIVISOR - 1) / MOD_DIVISOR);
    end
    f = 2 * (reg_cutoff + ((reg_key_track * longint'(s.note_key)) >>> 9)) + mod_term;
    if (f > reg_cut_limit) f = reg_cut_limit;
    if (f < 1) f = 1;

    q     = DAMP_TWO - ((reg_resonance * DAMPING_K) >>> 16);
    g     = reg_out_gain * GAIN_SCALE;
    drive = audio * (64'sd1 <<< DRIVE_SHIFT);

    low_a  = clamp_integ(low_a + mul_floor(f, band_a, SECT_SHIFT));
    hp_a   = clamp_integ(drive - low_a - mul_floor(q, band_a, SECT_SHIFT));
    band_a = clamp_integ(band_a + mul_floor(f, hp_a, SECT_SHIFT));

    low_b  = clamp_integ(low_b + mul_floor(f, band_b, SECT_SHIFT));
    hp_b   = clamp_integ(low_a - low_b - mul_floor(q, band_b, SECT_SHIFT));
    band_b = clamp_integ(band_b + mul_floor(f, hp_b, SECT_SHIFT));

    case (reg_response)
      RESP_BAND: tap = band_b;
      RESP_HIGH: tap = hp_b;
      default:   tap = low_b;
    endcase

    r = mixv + mul_floor(tap, g, GAIN_SHIFT);
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    return r[SAMPLE_W-1:0];
  endfunction

  function automatic logic [16:0] pick_coef();
    case ($urandom_range(7))
      0:       return COEF_ZERO;
      1:       return COEF_TOP;
      2:       return COEF_ONE;
      3:       return 17'($urandom_range(1024));
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [16:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_CUTOFF:    reg_cutoff    = val;
      REG_RESONANCE: reg_resonance = val;
      REG_MOD_DEPTH: reg_mod_depth = val;
      REG_KEY_TRACK: reg_key_track = val;
      REG_OUT_GAIN:  reg_out_gain  = val;
      REG_RESP_SEL:  reg_response  = val[1:0];
      REG_CUT_LIMIT: reg_cut_limit = val;
      default: ;
    endcase
  endtask

  // Write every register, then drop the write enable
  task automatic set_filter(input logic [16:0] cut, input logic [16:0] res,
                            input logic [16:0] depth, input logic [16:0] track,
                            input logic [16:0] gain, input logic [16:0] resp_word,
                            input logic [16:0] limit);
    write_reg(REG_CUTOFF, cut);
    write_reg(REG_RESONANCE, res);
    write_reg(REG_MOD_DEPTH, depth);
    write_reg(REG_KEY_TRACK, track);
    write_reg(REG_OUT_GAIN, gain);
    write_reg(REG_RESP_SEL, resp_word);
    write_reg(REG_CUT_LIMIT, limit);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_sample(input logic signed [23:0] audio, input logic signed [23:0] modv,
                             input logic [6:0] key, input logic start,
                             input logic signed [23:0] mixv);
    csvf_in_t item;
    item.audio_in   = audio;
    item.mod_in     = modv;
    item.note_key   = key;
    item.note_start = start;
    item.mix_in     = mixv;
    pending_samples.push_back(item);
  endtask

  // Hold until every queued sample is sent and every result is back
  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_ch.valid || expected_mix.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample driver: predict on each transfer, then present the next sample
  always @(posedge clk) begin : sample_driver
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_mix.push_back(filter_sample(in_ch.data));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= pending_samples.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each transfer with the oldest prediction
  always @(posedge clk) begin : result_monitor
    logic signed [SAMPLE_W-1:0] want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_mix.size() == 0) begin
          $error("mix_out: expected none, actual %0d", out_ch.data.mix_out);
          errors++;
        end else begin
          want = expected_mix.pop_front();
          if (out_ch.data.mix_out !== want) begin
            $error("mix_out: expected %0d, actual %0d", want, out_ch.data.mix_out);
            errors++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_cascaded_state_variable_filter_unit: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int                note_left;
    int                level;
    logic [6:0]        key;
    logic              start;
    logic [1:0]        resp;
    logic signed [23:0] audio, modv, mixv;

    note_left    = 0;
    level        = 0;
    key          = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    stall_cycles = 0;
    rst_n        = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: full-scale drive, mix saturation, both coefficient clamps
    push_sample(SAMPLE_MAX, SAMPLE_ZERO, 7'd0, 1'b1, SAMPLE_ZERO);
    push_sample(SAMPLE_MAX, SAMPLE_ZERO, 7'd0, 1'b0, SAMPLE_ZERO);
    push_sample(SAMPLE_MAX, SAMPLE_ZERO, 7'd0, 1'b0, SAMPLE_ZERO);
    push_sample(SAMPLE_MIN, SAMPLE_ZERO, KEY_TOP, 1'b0, SAMPLE_MIN);
    push_sample(SAMPLE_MAX, SAMPLE_MAX, 7'd64, 1'b0, SAMPLE_MAX);
    push_sample(SAMPLE_MIN, SAMPLE_MIN, 7'd0, 1'b0, SAMPLE_MAX);
    push_sample(SAMPLE_MIN, SAMPLE_MIN, 7'd0, 1'b0, SAMPLE_MIN);
    push_sample(SAMPLE_ZERO, SAMPLE_ZERO, 7'd0, 1'b1, SAMPLE_MIN);
    wait_drained();

    // Bandpass, zero limit forces the lowest coefficient, negative damping
    set_filter(COEF_TOP, COEF_TOP, COEF_TOP, COEF_TOP, COEF_TOP, {15'd0, RESP_BAND}, COEF_ZERO);
    push_sample(SAMPLE_MAX, SAMPLE_ZERO, KEY_TOP, 1'b1, SAMPLE_ZERO);
    push_sample(SAMPLE_MIN, SAMPLE_MAX, KEY_TOP, 1'b0, SAMPLE_ZERO);
    push_sample(SAMPLE_MAX, SAMPLE_MIN, 7'd0, 1'b0, SAMPLE_MAX);
    push_sample(SAMPLE_MAX, SAMPLE_ZERO, KEY_TOP, 1'b0, SAMPLE_MIN);
    push_sample(24'sh3039, 24'sh0BEEF, 7'd60, 1'b0, 24'sh00100);
    wait_drained();

    // Highpass with zero gain and zero base: output equals the mix input
    set_filter(COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO, {15'd0, RESP_HIGH},
               COEF_TOP);
    push_sample(SAMPLE_MAX, SAMPLE_MIN, KEY_TOP, 1'b1, 24'sh123456);
    push_sample(SAMPLE_MIN, SAMPLE_MAX, 7'd0, 1'b0, SAMPLE_MIN);
    push_sample(SAMPLE_MAX, SAMPLE_ZERO, 7'd1, 1'b0, SAMPLE_MAX);
    push_sample(SAMPLE_ZERO, SAMPLE_ZERO, 7'd0, 1'b0, SAMPLE_ZERO);
    wait_drained();

    // Unused selector, negative damping: drive the integrators into saturation
    set_filter(COEF_ONE, COEF_TOP, COEF_TOP, COEF_ONE, COEF_TOP, {15'd0, RESP_LOW_ALT}, COEF_TOP);
    push_sample(SAMPLE_MAX, SAMPLE_MAX, KEY_TOP, 1'b1, SAMPLE_ZERO);
    repeat (6) push_sample(SAMPLE_MAX, SAMPLE_MAX, KEY_TOP, 1'b0, SAMPLE_ZERO);
    wait_drained();

    // Random phases: notes of random length with random content
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0:       resp = RESP_LOW;
        1:       resp = RESP_BAND;
        2:       resp = RESP_HIGH;
        default: resp = RESP_LOW_ALT;
      endcase
      set_filter(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                 {15'($urandom), resp}, pick_coef());
      idle_pct = (p == CALM_PHASE) ? 0 : PCT_IDLE;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (note_left == 0) begin
          key       = 7'($urandom_range(127));
          start     = 1'b1;
          note_left = $urandom_range(40, 4);
          level     = $urandom_range(3);
        end else begin
          start = ($urandom_range(49) == 0);
        end
        note_left--;
        audio = 24'($urandom);
        case (level)
          0:       audio = audio >>> 11;
          1:       audio = audio >>> 4;
          2:       ;
          default: if ($urandom_range(3) == 0) audio = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
        endcase
        modv = 24'($urandom);
        if ($urandom_range(1)) modv = modv >>> 8;
        mixv = ($urandom_range(3) == 0) ? SAMPLE_ZERO : 24'($urandom);
        push_sample(audio, modv, key, start, mixv);
      end
      wait_drained();
    end

    idle_pct = PCT_IDLE;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_cascaded_state_variable_filter_unit: done, clean");
    end else begin
      $display("tb_cascaded_state_variable_filter_unit: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/csvf_pkg.sv
hdl/csvf_if.sv
hdl/csvf_mul.sv
hdl/cascaded_state_variable_filter_unit.sv
sim/tb_cascaded_state_variable_filter_unit.sv
